### hdl/pst_pkg.sv
// Shared types, constants and map functions for the permutation segment tree.
// Used by pst_ctrl, pst_datapath, pst_checker and the top level; no dependencies.
package pst_pkg;

    // Map word: eight 3-bit entries, entry i is the image of element i
    localparam int MAP_W   = 24;
    localparam int ENTRY_W = 3;
    localparam int ELEMS   = 8;
    localparam logic [MAP_W-1:0] IDENTITY_MAP = 24'hFAC688;

    // Field widths
    localparam int POS_W   = 10;
    localparam int START_W = 10;
    localparam int END_W   = 11;
    localparam int LCNT_W  = 11;
    localparam logic [LCNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

    // Stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // Operation codes carried on the input tuser
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;     // capture input word and range checks
        logic clr_write;     // write identity at the clear address
        logic leaf_write;    // write the new leaf map
        logic sib_read;      // read the sibling of the current node
        logic parent_write;  // combine with sibling, write the parent
        logic lo_read;       // read node lo
        logic lo_step;       // fold node lo into the left accumulator, step lo
        logic hi_read;       // decrement hi and read node hi
        logic hi_step;       // fold node hi into the right accumulator, halve
        logic shift;         // halve lo and hi
        logic final_comp;    // join left and right accumulators
        logic load_out;      // load the output word
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic err;
        logic op;
        logic at_root;
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
    } t_status;

    // Compose two maps, first applied first: r[i] = second[first[i]]
    function automatic logic [MAP_W-1:0] compose(input logic [MAP_W-1:0] first,
                                                 input logic [MAP_W-1:0] second);
        logic [MAP_W-1:0]   r;
        logic [ENTRY_W-1:0] e;
        r = '0;
        for (int i = 0; i < ELEMS; i++) begin
            e = first[ENTRY_W*i +: ENTRY_W];
            r[ENTRY_W*i +: ENTRY_W] = second[ENTRY_W*e +: ENTRY_W];
        end
        return r;
    endfunction

    // Inverse entry j is the lowest element mapping to j, zero if none
    function automatic logic [MAP_W-1:0] invert(input logic [MAP_W-1:0] m);
        logic [MAP_W-1:0] r;
        r = '0;
        for (int j = 0; j < ELEMS; j++) begin
            for (int k = ELEMS - 1; k >= 0; k--) begin
                if (m[ENTRY_W*k +: ENTRY_W] == ENTRY_W'(j)) begin
                    r[ENTRY_W*j +: ENTRY_W] = ENTRY_W'(k);
                end
            end
        end
        return r;
    endfunction

endpackage

### hdl/pst_ctrl.sv
// Sequencer for the permutation segment tree: clearing pass, leaf update
// climb and range query walk. Depends on pst_pkg for command/status structs.
module pst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pst_pkg::t_cmd     o_cmd,
    input  pst_pkg::t_status  i_status
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_U_LEAF,
        ST_U_READ,
        ST_U_WRITE,
        ST_Q_LOOP,
        ST_Q_LWAIT,
        ST_Q_HI,
        ST_Q_HWAIT,
        ST_Q_FINAL,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.err) begin
                    n_state = ST_FINISH;
                end else if (i_status.op == pst_pkg::OP_SET) begin
                    n_state = ST_U_LEAF;
                end else begin
                    n_state = ST_Q_LOOP;
                end
            end
            ST_U_LEAF: begin
                o_cmd.leaf_write = 1'b1;
                n_state = ST_U_READ;
            end
            ST_U_READ: begin
                if (i_status.at_root) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.sib_read = 1'b1;
                    n_state = ST_U_WRITE;
                end
            end
            ST_U_WRITE: begin
                o_cmd.parent_write = 1'b1;
                n_state = ST_U_READ;
            end
            ST_Q_LOOP: begin
                if (!i_status.lo_lt_hi) begin
                    n_state = ST_Q_FINAL;
                end else if (i_status.lo_odd) begin
                    o_cmd.lo_read = 1'b1;
                    n_state = ST_Q_LWAIT;
                end else begin
                    n_state = ST_Q_HI;
                end
            end
            ST_Q_LWAIT: begin
                o_cmd.lo_step = 1'b1;
                n_state = ST_Q_HI;
            end
            ST_Q_HI: begin
                if (i_status.hi_odd) begin
                    o_cmd.hi_read = 1'b1;
                    n_state = ST_Q_HWAIT;
                end else begin
                    o_cmd.shift = 1'b1;
                    n_state = ST_Q_LOOP;
                end
            end
            ST_Q_HWAIT: begin
                o_cmd.hi_step = 1'b1;
                n_state = ST_Q_LOOP;
            end
            ST_Q_FINAL: begin
                o_cmd.final_comp = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/pst_datapath.sv
// Datapath of the permutation segment tree: node memory, leaf count register,
// climb and walk indexes, accumulators and output word. Depends on pst_pkg.
module pst_datapath #(
    parameter int LEAVES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pst_pkg::LCNT_W-1:0]         i_cfg_wdata,
    input  logic                               i_op,
    input  logic [pst_pkg::POS_W-1:0]          i_position,
    input  logic [pst_pkg::MAP_W-1:0]          i_map_word,
    input  logic [pst_pkg::START_W-1:0]        i_range_start,
    input  logic [pst_pkg::END_W-1:0]          i_range_end,
    input  pst_pkg::t_cmd                      i_cmd,
    output pst_pkg::t_status                   o_status,
    output logic [pst_pkg::M_TDATA_W-1:0]      o_out_data,
    output logic                               o_out_err
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int NW    = $clog2(DEPTH);
    localparam int HW    = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(LEAVES + 1);
    localparam int CW    = (LW > pst_pkg::LCNT_W) ? LW : pst_pkg::LCNT_W;
    localparam logic [HW-1:0] LEAF_BASE = HW'(LEAVES);
    localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);

    logic [pst_pkg::MAP_W-1:0] mem [DEPTH];
    logic [pst_pkg::MAP_W-1:0] r_rdata;

    logic [pst_pkg::LCNT_W-1:0] r_leaf_count;
    logic [NW-1:0]              r_clr_addr;

    logic                      r_op;
    logic                      r_err;
    logic [pst_pkg::MAP_W-1:0] r_map;
    logic [pst_pkg::MAP_W-1:0] r_cur;
    logic [pst_pkg::MAP_W-1:0] r_acc_l;
    logic [pst_pkg::MAP_W-1:0] r_acc_r;
    logic [pst_pkg::MAP_W-1:0] r_result;
    logic [HW-1:0]             r_k;
    logic [HW-1:0]             r_lo;
    logic [HW-1:0]             r_hi;
    logic [pst_pkg::M_TDATA_W-1:0] r_out_data;
    logic                      r_out_err;

    logic [CW-1:0]             limit;
    logic [CW-1:0]             lcnt_c;
    logic [CW-1:0]             pos_c;
    logic [CW-1:0]             start_c;
    logic [CW-1:0]             end_c;
    logic                      err_now;
    logic [HW-1:0]             parent;
    logic [HW-1:0]             hi_dec;
    logic [pst_pkg::MAP_W-1:0] combined;
    logic                      mem_we;
    logic [NW-1:0]             mem_waddr;
    logic [pst_pkg::MAP_W-1:0] mem_wdata;
    logic [NW-1:0]             mem_raddr;

    // Range checks against the usable limit
    assign lcnt_c  = CW'(r_leaf_count);
    assign limit   = (lcnt_c < CW'(LEAVES)) ? lcnt_c : CW'(LEAVES);
    assign pos_c   = CW'(i_position);
    assign start_c = CW'(i_range_start);
    assign end_c   = CW'(i_range_end);
    assign err_now = (i_op == pst_pkg::OP_SET) ? (pos_c >= limit)
                                               : ((start_c > end_c) || (end_c > limit));

    // Climb step: current node joins its sibling in tree order
    assign parent   = r_k >> 1;
    assign hi_dec   = r_hi - HW'(1);
    assign combined = r_k[0] ? pst_pkg::compose(r_rdata, r_cur)
                             : pst_pkg::compose(r_cur, r_rdata);

    // Select memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = pst_pkg::IDENTITY_MAP;
        if (i_cmd.clr_write) begin
            mem_we = 1'b1;
        end else if (i_cmd.leaf_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_k[NW-1:0];
            mem_wdata = r_map;
        end else if (i_cmd.parent_write) begin
            mem_we    = 1'b1;
            mem_waddr = parent[NW-1:0];
            mem_wdata = combined;
        end
    end

    // Select memory read address
    always_comb begin
        mem_raddr = r_lo[NW-1:0];
        if (i_cmd.sib_read) begin
            mem_raddr = r_k[NW-1:0] ^ NW'(1);
        end else if (i_cmd.hi_read) begin
            mem_raddr = hi_dec[NW-1:0];
        end
    end

    // Node memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Leaf count register and clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= pst_pkg::LEAF_COUNT_RESET;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_leaf_count <= i_cfg_wdata;
            end
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + NW'(1);
            end
        end
    end

    // Item registers, indexes and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_err   <= err_now;
            r_map   <= i_map_word;
            r_k     <= HW'(i_position) + LEAF_BASE;
            r_lo    <= HW'(i_range_start) + LEAF_BASE;
            r_hi    <= HW'(i_range_end) + LEAF_BASE;
            r_acc_l <= pst_pkg::IDENTITY_MAP;
            r_acc_r <= pst_pkg::IDENTITY_MAP;
        end
        if (i_cmd.leaf_write) begin
            r_cur <= r_map;
        end
        if (i_cmd.parent_write) begin
            r_cur <= combined;
            r_k   <= parent;
        end
        if (i_cmd.lo_step) begin
            r_acc_l <= pst_pkg::compose(r_acc_l, r_rdata);
            r_lo    <= r_lo + HW'(1);
        end
        if (i_cmd.hi_read) begin
            r_hi <= hi_dec;
        end
        if (i_cmd.hi_step) begin
            r_acc_r <= pst_pkg::compose(r_rdata, r_acc_r);
            r_lo    <= r_lo >> 1;
            r_hi    <= r_hi >> 1;
        end
        if (i_cmd.shift) begin
            r_lo <= r_lo >> 1;
            r_hi <= r_hi >> 1;
        end
        if (i_cmd.final_comp) begin
            r_result <= pst_pkg::compose(r_acc_l, r_acc_r);
        end
    end

    // Output word: maps only for a good query
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_err <= r_err;
            if (r_op == pst_pkg::OP_QUERY && !r_err) begin
                r_out_data <= {pst_pkg::invert(r_result), r_result};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_err  = r_out_err;

    assign o_status.clr_last = (r_clr_addr == LAST_NODE);
    assign o_status.err      = r_err;
    assign o_status.op       = r_op;
    assign o_status.at_root  = (r_k == HW'(1));
    assign o_status.lo_lt_hi = (r_lo < r_hi);
    assign o_status.lo_odd   = r_lo[0];
    assign o_status.hi_odd   = r_hi[0];

endmodule

### hdl/permutation_segment_tree.sv
// Top level of the permutation segment tree: stream ports, config register port.
// Instantiates pst_ctrl and pst_datapath; types and constants from pst_pkg.
//
// Keeps maps of eight elements in a segment tree of 2*LEAVES nodes held in one
// memory with a single registered read port, which sets the item time. After
// reset a clearing pass writes the identity map into every node, one node a
// cycle, during which no word is accepted. A set word then does one memory read
// and one write per tree level on the climb to the root; a query walks at most
// log2(LEAVES) + 1 levels; an out-of-range word skips the tree and goes straight
// to the output. One word is worked on at a time; a finished result waits in the
// output register while the next word is taken. The user must write the
// leaf_count register only while the block is idle; the block itself does not
// enforce it.
module permutation_segment_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: leaf_count
    input  logic                               i_cfg_we,
    input  logic [pst_pkg::LCNT_W-1:0]         i_cfg_wdata,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // position[9:0], map_word[33:10], range_start[43:34], range_end[54:44], zero[55]
    input  logic [pst_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // op[0]
    input  logic [0:0]                         s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // composed_map[23:0], inverse_map[47:24]
    output logic [pst_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // range_error[0]
    output logic [0:0]                         m_axis_tuser
);

    pst_pkg::t_cmd    cmd;
    pst_pkg::t_status status;
    logic             out_err;

    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pst_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (s_axis_tuser[0]),
        .i_position    (s_axis_tdata[9:0]),
        .i_map_word    (s_axis_tdata[33:10]),
        .i_range_start (s_axis_tdata[43:34]),
        .i_range_end   (s_axis_tdata[54:44]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_data    (m_axis_tdata),
        .o_out_err     (out_err)
    );

    assign m_axis_tuser[0] = out_err;

endmodule

### hdl/pst_checker.sv
// Port-level checks for permutation_segment_tree, attached with bind.
// Depends on pst_pkg for stream word widths.
module pst_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [pst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic [0:0]                    m_axis_tuser
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Out-of-range result carries zero maps
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("range error with nonzero maps");

    // Busy in the cycle after a word is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    // Reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("not quiet after reset");

endmodule

bind permutation_segment_tree pst_checker u_pst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
